// ----- design/srrip_pkg.sv -----
package srrip_pkg;

	localparam int ENTRIES   = 16;
	localparam int PAGE_BITS = 32;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int CFG_W     = 5;
	localparam int LIM_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int RRPV_W    = 2;

	typedef logic [PAGE_BITS-1:0] tag_t;
	typedef logic [RRPV_W-1:0]    rrpv_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CFG_W-1:0]     cfg_t;

	localparam rrpv_t RRPV_DIST = 2'd3;
	localparam rrpv_t RRPV_LONG = 2'd2;
	localparam rrpv_t RRPV_NEAR = 2'd0;

endpackage

// ----- design/srrip_fully_assoc_replacement_unit.sv -----
// channel | signals                                  | direction
// --------+------------------------------------------+----------
// in      | in_valid, in_stall, page                 | item in
// out     | out_valid, out_stall, hit, evicted,      | item out
//         | evicted_page                             |
// cfg     | cfg_valid, cfg_ready, active_entries     | register write
//
// one tag/value read port and one write port, stepped one entry a cycle by a sequencer
// hit at row position p: search up to p, then shift the row down by one
// miss, not full: search the n resident entries, then append; miss, full: search, aging pass, replace
// in_stall is high from acceptance until the result goes into the output register
// the output register holds a result under out_stall; the next item is taken meanwhile
// arst_n clears the resident count, the sequencer and the output valid; active_entries resets to 16
module srrip_fully_assoc_replacement_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  srrip_pkg::tag_t    page,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic               evicted,
	output srrip_pkg::tag_t    evicted_page,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  srrip_pkg::cfg_t    active_entries
);
	import srrip_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_MISS   = 3'd3;
	localparam logic [2:0] S_LAST   = 3'd4;
	localparam logic [2:0] S_AGE    = 3'd5;
	localparam logic [2:0] S_REPL   = 3'd6;

	tag_t  tag_q  [ENTRIES];
	rrpv_t rrpv_q [ENTRIES];

	logic [2:0] state_q, state_d;
	cnt_t  idx_q, idx_d;
	cnt_t  count_q, count_d;
	cnt_t  pos_q, pos_d;
	logic  found_q, found_d;
	rrpv_t add_q, add_d;
	tag_t  page_q, page_d;
	cfg_t  act_q;

	logic  out_valid_q, hit_q, evicted_q;
	tag_t  evicted_page_q;

	idx_t  rd_idx;
	tag_t  rd_tag;
	rrpv_t rd_rrpv;
	logic  tag_we, rrpv_we;
	tag_t  wr_tag;
	rrpv_t wr_rrpv;
	logic  load_out, res_hit, res_ev;
	tag_t  res_evp;
	logic  out_free;
	logic [LIM_W-1:0] lim;
	logic [RRPV_W:0]  aged_sum;
	rrpv_t aged;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign evicted   = evicted_q;
	assign evicted_page = evicted_page_q;

	// clamp the register into 1 .. ENTRIES
	always_comb begin
		if (act_q == '0) begin
			lim = LIM_W'(1);
		end else if (LIM_W'(act_q) > LIM_W'(ENTRIES)) begin
			lim = LIM_W'(ENTRIES);
		end else begin
			lim = LIM_W'(act_q);
		end
	end

	assign rd_tag  = tag_q[rd_idx];
	assign rd_rrpv = rrpv_q[rd_idx];

	// aging adds with saturation at the distant value
	assign aged_sum = {1'b0, rd_rrpv} + {1'b0, add_q};
	assign aged     = aged_sum[RRPV_W] ? RRPV_DIST : aged_sum[RRPV_W-1:0];

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		count_d  = count_q;
		pos_d    = pos_q;
		found_d  = found_q;
		add_d    = add_q;
		page_d   = page_q;
		rd_idx   = idx_q[IDX_W-1:0];
		tag_we   = 1'b0;
		rrpv_we  = 1'b0;
		wr_tag   = page_q;
		wr_rrpv  = RRPV_LONG;
		load_out = 1'b0;
		res_hit  = 1'b0;
		res_ev   = 1'b0;
		res_evp  = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					page_d  = page;
					idx_d   = '0;
					found_d = 1'b0;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (idx_q == count_q) begin
					state_d = S_MISS;
				end else if (rd_tag == page_q) begin
					state_d = S_SHIFT;
				end else begin
					idx_d = CNT_W'(idx_q + 1'b1);
				end
			end
			S_SHIFT: begin
				// move entries down one place, from the hit position toward the head
				if (idx_q == '0) begin
					if (out_free) begin
						tag_we   = 1'b1;
						rrpv_we  = 1'b1;
						wr_rrpv  = RRPV_NEAR;
						load_out = 1'b1;
						res_hit  = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					rd_idx  = IDX_W'(idx_q[IDX_W-1:0] - 1'b1);
					tag_we  = 1'b1;
					rrpv_we = 1'b1;
					wr_tag  = rd_tag;
					wr_rrpv = rd_rrpv;
					idx_d   = CNT_W'(idx_q - 1'b1);
				end
			end
			S_MISS: begin
				if (LIM_W'(count_q) < lim) begin
					// append at the end of the row, idx_q equals count_q here
					if (out_free) begin
						tag_we   = 1'b1;
						rrpv_we  = 1'b1;
						count_d  = CNT_W'(count_q + 1'b1);
						load_out = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					idx_d   = CNT_W'(count_q - 1'b1);
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				add_d   = RRPV_W'(RRPV_DIST - rd_rrpv);
				idx_d   = '0;
				state_d = S_AGE;
			end
			S_AGE: begin
				rrpv_we = 1'b1;
				wr_rrpv = aged;
				if (!found_q && aged == RRPV_DIST) begin
					found_d = 1'b1;
					pos_d   = idx_q;
				end
				if (idx_q == CNT_W'(count_q - 1'b1)) begin
					if (found_q) begin
						idx_d = pos_q;
					end else if (aged == RRPV_DIST) begin
						idx_d = idx_q;
					end else begin
						idx_d = CNT_W'(count_q - 1'b1);
					end
					state_d = S_REPL;
				end else begin
					idx_d = CNT_W'(idx_q + 1'b1);
				end
			end
			S_REPL: begin
				if (out_free) begin
					res_evp  = rd_tag;
					tag_we   = 1'b1;
					rrpv_we  = 1'b1;
					load_out = 1'b1;
					res_ev   = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			found_q     <= 1'b0;
			act_q       <= CFG_W'(16);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			found_q <= found_d;
			if (cfg_valid && cfg_ready) begin
				act_q <= active_entries;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		pos_q  <= pos_d;
		add_q  <= add_d;
		page_q <= page_d;
		if (load_out) begin
			hit_q          <= res_hit;
			evicted_q      <= res_ev;
			evicted_page_q <= res_evp;
		end
		if (tag_we) begin
			tag_q[idx_q[IDX_W-1:0]] <= wr_tag;
		end
		if (rrpv_we) begin
			rrpv_q[idx_q[IDX_W-1:0]] <= wr_rrpv;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LIM_W'(count_q) <= LIM_W'(ENTRIES))
		else $error("resident count above entry count");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("resident count changed by other than one");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && evicted_q))
		else $error("result reports both hit and eviction");

	a_evp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !evicted_q) |-> evicted_page_q == '0)
		else $error("evicted page not zero without eviction");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (state_q != S_IDLE && out_free))
		else $error("result loaded while idle or output blocked");
`endif

endmodule
